[hw/rtl/gpvw_pkg.sv]
// Package for the gravity point vertex warp block.
// Holds payload structs, table entry layout, command/status structs and codes.
// No dependencies.
`timescale 1ns / 1ps

package gpvw_pkg;

  // Parameter defaults
  localparam int unsigned MAX_POINTS_DEF   = 16;
  localparam int unsigned SINE_ENTRIES_DEF = 1024;

  // Fixed datapath widths, sized for the largest sine table (4096 entries)
  localparam int unsigned IDX_W  = 12;  // sine index
  localparam int unsigned DIV_NW = 48;  // divider dividend / quotient
  localparam int unsigned DIV_DW = 32;  // divider divisor
  localparam int unsigned SQ_W   = 56;  // square root radicand
  localparam int unsigned SQR_W  = 28;  // square root result
  localparam int unsigned ACC_W  = 56;  // displacement accumulators

  // Operating modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_MAP   = 2'd2;

  // Multiplier operand selects
  localparam logic [3:0] MUL_DXX  = 4'd0;
  localparam logic [3:0] MUL_DYY  = 4'd1;
  localparam logic [3:0] MUL_RR   = 4'd2;
  localparam logic [3:0] MUL_NN   = 4'd3;
  localparam logic [3:0] MUL_P    = 4'd4;
  localparam logic [3:0] MUL_SS   = 4'd5;
  localparam logic [3:0] MUL_CUBE = 4'd6;
  localparam logic [3:0] MUL_MAG  = 4'd7;
  localparam logic [3:0] MUL_AX   = 4'd8;
  localparam logic [3:0] MUL_AY   = 4'd9;

  // Divider operand selects
  localparam logic [1:0] DIV_IDX  = 2'd0;
  localparam logic [1:0] DIV_SINE = 2'd1;
  localparam logic [1:0] DIV_AX   = 2'd2;
  localparam logic [1:0] DIV_AY   = 2'd3;

  // Square root operand selects
  localparam logic SQ_IDX = 1'b0;
  localparam logic SQ_LEN = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        radius;
    logic signed [11:0] force_req;
    logic               invert;
  } gpvw_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               status;
    logic [4:0]         points_hit;
  } gpvw_out_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [15:0]        rad;
    logic signed [11:0] frc;
    logic               inv;
  } gpvw_entry_t;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic       ld_diff;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic       ld_d2a;
    logic       ld_d2b;
    logic       hit_chk;
    logic       sq_start;
    logic       sq_sel;
    logic       div_start;
    logic [1:0] div_sel;
    logic       ld_idx;
    logic       ld_s;
    logic       ld_sk_cube;
    logic       ld_den;
    logic       ld_sx;
    logic       ld_sy;
    logic       ptr_inc;
    logic       out_load;
  } gpvw_cmd_t;

  typedef struct packed {
    logic map_end;
    logic hit;
    logic zero_d;
    logic k1;
    logic sq_done;
    logic div_done;
  } gpvw_sts_t;

endpackage

[hw/rtl/gpvw_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gpvw_pkg for widths.
`timescale 1ns / 1ps

module gpvw_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gpvw_pkg::DIV_NW-1:0]   dividend_i,
  input  logic [gpvw_pkg::DIV_DW-1:0]   divisor_i,
  output logic [gpvw_pkg::DIV_NW-1:0]   quot_o,
  output logic                          done_o
);

  localparam int unsigned NW  = gpvw_pkg::DIV_NW;
  localparam int unsigned DW  = gpvw_pkg::DIV_DW;
  localparam int unsigned CW  = $clog2(NW);
  localparam logic [CW-1:0] LAST = CW'(NW - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   dvs_q, dvs_d;
  logic [DW:0]     trial;
  logic            fits;

  // one restoring step
  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NW-2:0], fits};
      rem_d = fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

[hw/rtl/gpvw_sqrt.sv]
// Digit-by-digit floor square root, one result bit per cycle.
// Depends on gpvw_pkg for widths.
`timescale 1ns / 1ps

module gpvw_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gpvw_pkg::SQ_W-1:0]    radicand_i,
  output logic [gpvw_pkg::SQR_W-1:0]   root_o,
  output logic                         done_o
);

  localparam int unsigned W  = gpvw_pkg::SQ_W;
  localparam int unsigned RW = gpvw_pkg::SQR_W;
  localparam int unsigned CW = $clog2(RW);
  localparam logic [CW-1:0] LAST = CW'(RW - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rad_q, rad_d;
  logic [RW-1:0] root_q, root_d;
  logic [RW+1:0] rem_q, rem_d;
  logic [RW+3:0] cur;
  logic [RW+3:0] trial;
  logic          fits;

  // bring down two bits, try root*4+1
  assign cur   = {rem_q, rad_q[W-1:W-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign fits  = cur >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      root_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[W-3:0], 2'b00};
      root_d = {root_q[RW-2:0], fits};
      rem_d  = fits ? (RW+2)'(cur - trial) : cur[RW+1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

[hw/rtl/gpvw_dpath.sv]
// Datapath: point table memory, shared multiplier, divider and square root,
// accumulators and output register. Depends on gpvw_pkg, gpvw_div, gpvw_sqrt.
`timescale 1ns / 1ps

module gpvw_dpath #(
  parameter int unsigned MAX_POINTS   = gpvw_pkg::MAX_POINTS_DEF,
  parameter int unsigned SINE_ENTRIES = gpvw_pkg::SINE_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gpvw_pkg::gpvw_cmd_t  cmd_i,
  output gpvw_pkg::gpvw_sts_t  sts_o,
  input  gpvw_pkg::gpvw_in_t   in_data_i,
  output gpvw_pkg::gpvw_out_t  out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned ACC_W = gpvw_pkg::ACC_W;
  localparam int unsigned IDX_W = gpvw_pkg::IDX_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
  localparam logic [31:0] NN  = 32'(SINE_ENTRIES * SINE_ENTRIES);
  localparam logic [31:0] K5  = 32'(5 * SINE_ENTRIES * SINE_ENTRIES);
  localparam logic [31:0] NE  = 32'(SINE_ENTRIES);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  // point table
  gpvw_pkg::gpvw_entry_t mem [MAX_POINTS];
  gpvw_pkg::gpvw_entry_t ent_q;
  gpvw_pkg::gpvw_entry_t wr_ent;

  logic [CNT_W-1:0] count_q, ptr_q;
  logic [4:0]       hits_q;
  logic             res_map_q, res_status_q;
  logic signed [15:0] vx_q, vy_q;
  logic signed [ACC_W-1:0] accx_q, accy_q;
  logic signed [16:0] dx_q, dy_q;
  logic [15:0]      adx, ady;
  logic [33:0]      d2_q;
  logic             k1_q;
  logic [IDX_W-1:0] idx_q;
  logic [16:0]      s_q, sk_q;
  logic [31:0]      den_q;
  logic [28:0]      mag_q;
  logic [11:0]      afrc;
  logic [63:0]      mul_q;
  logic [31:0]      mul_a, mul_b;
  logic             full;

  gpvw_pkg::gpvw_out_t out_q;

  // divider and square root operands
  logic                        div_done, sq_done;
  logic [gpvw_pkg::DIV_NW-1:0] div_n, quot;
  logic [gpvw_pkg::DIV_DW-1:0] div_d;
  logic [gpvw_pkg::SQ_W-1:0]   sq_in;
  logic [gpvw_pkg::SQR_W-1:0]  root;
  logic [31:0]                 den_new;
  logic                        neg_x, neg_y;
  logic signed [ACC_W-1:0]     q_ext, sum_x, sum_y;

  assign full = count_q >= CNT_MAX;
  assign wr_ent.px  = in_data_i.x;
  assign wr_ent.py  = in_data_i.y;
  assign wr_ent.rad = in_data_i.radius;
  assign wr_ent.frc = in_data_i.force_req;
  assign wr_ent.inv = in_data_i.invert;

  // table write on add, registered read for map
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_data_i.mode == gpvw_pkg::MODE_ADD && !full) begin
      mem[count_q[AW-1:0]] <= wr_ent;
    end
    if (cmd_i.rd_en) begin
      ent_q <= mem[ptr_q[AW-1:0]];
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      hits_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        ptr_q  <= '0;
        hits_q <= '0;
        if (in_data_i.mode == gpvw_pkg::MODE_CLEAR) begin
          count_q <= '0;
        end else if (in_data_i.mode == gpvw_pkg::MODE_ADD && !full) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.hit_chk && sts_o.hit && hits_q != 5'd31) begin
        hits_q <= hits_q + 5'd1;
      end
    end
  end

  assign adx  = dx_q[16] ? 16'(-dx_q) : dx_q[15:0];
  assign ady  = dy_q[16] ? 16'(-dy_q) : dy_q[15:0];
  assign afrc = ent_q.frc[11] ? 12'(-ent_q.frc) : ent_q.frc;

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      gpvw_pkg::MUL_DXX:  begin mul_a = 32'(adx);           mul_b = 32'(adx);   end
      gpvw_pkg::MUL_DYY:  begin mul_a = 32'(ady);           mul_b = 32'(ady);   end
      gpvw_pkg::MUL_RR:   begin mul_a = 32'(ent_q.rad);     mul_b = 32'(ent_q.rad); end
      gpvw_pkg::MUL_NN:   begin mul_a = d2_q[31:0];         mul_b = NN;         end
      gpvw_pkg::MUL_P:    begin mul_a = 32'(idx_q);         mul_b = NE - 32'(idx_q); end
      gpvw_pkg::MUL_SS:   begin mul_a = 32'(s_q);           mul_b = 32'(s_q);   end
      gpvw_pkg::MUL_CUBE: begin mul_a = mul_q[47:16];       mul_b = 32'(s_q);   end
      gpvw_pkg::MUL_MAG:  begin mul_a = 32'(afrc);          mul_b = 32'(sk_q);  end
      gpvw_pkg::MUL_AX:   begin mul_a = 32'(mag_q);         mul_b = 32'(adx);   end
      gpvw_pkg::MUL_AY:   begin mul_a = 32'(mag_q);         mul_b = 32'(ady);   end
      default:            begin mul_a = '0;                 mul_b = '0;         end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      mul_q <= mul_a * mul_b;
    end
  end

  // divider operand select
  always_comb begin
    case (cmd_i.div_sel)
      gpvw_pkg::DIV_IDX: begin
        div_n = gpvw_pkg::DIV_NW'(root);
        div_d = 32'(ent_q.rad);
      end
      gpvw_pkg::DIV_SINE: begin
        div_n = {mul_q[27:0], 20'b0};
        div_d = K5 - {mul_q[29:0], 2'b00};
      end
      default: begin
        div_n = mul_q[47:0];
        div_d = den_q;
      end
    endcase
  end

  assign sq_in = (cmd_i.sq_sel == gpvw_pkg::SQ_LEN) ? {8'b0, d2_q[31:0], 16'b0}
                                                    : mul_q[55:0];

  gpvw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  gpvw_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sq_start),
    .radicand_i (sq_in),
    .root_o     (root),
    .done_o     (sq_done)
  );

  assign den_new = {root[23:0], 8'b0};
  assign q_ext   = $signed({8'b0, quot});
  // shift sign: force sign, axis sign and invert flag combine
  assign neg_x   = ent_q.frc[11] ^ dx_q[16] ^ ent_q.inv;
  assign neg_y   = ent_q.frc[11] ^ dy_q[16] ^ ent_q.inv;

  // per-point registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      vx_q         <= in_data_i.x;
      vy_q         <= in_data_i.y;
      accx_q       <= '0;
      accy_q       <= '0;
      res_map_q    <= in_data_i.mode == gpvw_pkg::MODE_MAP;
      res_status_q <= in_data_i.mode == gpvw_pkg::MODE_ADD && full;
    end
    if (cmd_i.ld_diff) begin
      dx_q <= 17'(vx_q) - 17'(ent_q.px);
      dy_q <= 17'(vy_q) - 17'(ent_q.py);
    end
    if (cmd_i.ld_d2a) d2_q <= 34'(mul_q[32:0]);
    if (cmd_i.ld_d2b) d2_q <= d2_q + 34'(mul_q[32:0]);
    if (cmd_i.hit_chk) k1_q <= {d2_q, 2'b00} < {4'b0, mul_q[31:0]};
    if (cmd_i.ld_idx) idx_q <= quot[IDX_W-1:0];
    if (cmd_i.ld_s) begin
      s_q  <= quot[16:0];
      sk_q <= quot[16:0];
    end
    if (cmd_i.ld_sk_cube) sk_q <= mul_q[32:16];
    if (cmd_i.ld_den) begin
      den_q <= den_new;
      mag_q <= (ent_q.inv && {3'b0, mul_q[28:0]} > den_new) ? den_new[28:0] : mul_q[28:0];
    end
    if (cmd_i.ld_sx) accx_q <= neg_x ? accx_q - q_ext : accx_q + q_ext;
    if (cmd_i.ld_sy) accy_q <= neg_y ? accy_q - q_ext : accy_q + q_ext;
  end

  // saturated result
  assign sum_x = ACC_W'(vx_q) + accx_q;
  assign sum_y = ACC_W'(vy_q) + accy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status     <= res_status_q;
      out_q.points_hit <= res_map_q ? hits_q : 5'd0;
      if (!res_map_q) begin
        out_q.out_x <= '0;
        out_q.out_y <= '0;
      end else begin
        out_q.out_x <= (sum_x > SAT_HI) ? 16'sd32767 :
                       (sum_x < SAT_LO) ? -16'sd32768 : sum_x[15:0];
        out_q.out_y <= (sum_y > SAT_HI) ? 16'sd32767 :
                       (sum_y < SAT_LO) ? -16'sd32768 : sum_y[15:0];
      end
    end
  end

  assign out_data_o     = out_q;
  assign sts_o.map_end  = ptr_q >= count_q;
  assign sts_o.hit      = d2_q < {2'b00, mul_q[31:0]};
  assign sts_o.zero_d   = d2_q == '0;
  assign sts_o.k1       = k1_q;
  assign sts_o.sq_done  = sq_done;
  assign sts_o.div_done = div_done;

endmodule

[hw/rtl/gpvw_ctrl.sv]
// Controller: sequences clear, add and map transactions over the datapath.
// Depends on gpvw_pkg.
`timescale 1ns / 1ps

module gpvw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           in_mode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  gpvw_pkg::gpvw_sts_t  sts_i,
  output gpvw_pkg::gpvw_cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_DIFF  = 5'd2;
  localparam logic [4:0] S_SQX   = 5'd3;
  localparam logic [4:0] S_SQY   = 5'd4;
  localparam logic [4:0] S_R2    = 5'd5;
  localparam logic [4:0] S_HIT   = 5'd6;
  localparam logic [4:0] S_SQ1   = 5'd7;
  localparam logic [4:0] S_SQ1W  = 5'd8;
  localparam logic [4:0] S_DIV1W = 5'd9;
  localparam logic [4:0] S_P     = 5'd10;
  localparam logic [4:0] S_SDIV  = 5'd11;
  localparam logic [4:0] S_SDIVW = 5'd12;
  localparam logic [4:0] S_C1    = 5'd13;
  localparam logic [4:0] S_C2    = 5'd14;
  localparam logic [4:0] S_C3    = 5'd15;
  localparam logic [4:0] S_MAG   = 5'd16;
  localparam logic [4:0] S_SQ2W  = 5'd17;
  localparam logic [4:0] S_AX    = 5'd18;
  localparam logic [4:0] S_AXD   = 5'd19;
  localparam logic [4:0] S_AXW   = 5'd20;
  localparam logic [4:0] S_AY    = 5'd21;
  localparam logic [4:0] S_AYD   = 5'd22;
  localparam logic [4:0] S_AYW   = 5'd23;
  localparam logic [4:0] S_DONE  = 5'd24;

  logic [4:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       out_free;

  assign out_free   = !ovalid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (in_mode_i == gpvw_pkg::MODE_MAP) ? S_RD : S_DONE;
        end
      end
      S_RD: begin
        if (sts_i.map_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.ld_diff = 1'b1;
        state_d = S_SQX;
      end
      S_SQX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gpvw_pkg::MUL_DXX;
        state_d = S_SQY;
      end
      S_SQY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gpvw_pkg::MUL_DYY;
        cmd_o.ld_d2a  = 1'b1;
        state_d = S_R2;
      end
      S_R2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gpvw_pkg::MUL_RR;
        cmd_o.ld_d2b  = 1'b1;
        state_d = S_HIT;
      end
      S_HIT: begin
        cmd_o.hit_chk = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gpvw_pkg::MUL_NN;
        if (sts_i.hit && !sts_i.zero_d) begin
          state_d = S_SQ1;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d = S_RD;
        end
      end
      S_SQ1: begin
        cmd_o.sq_start = 1'b1;
        cmd_o.sq_sel   = gpvw_pkg::SQ_IDX;
        state_d = S_SQ1W;
      end
      S_SQ1W: begin
        if (sts_i.sq_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = gpvw_pkg::DIV_IDX;
          state_d = S_DIV1W;
        end
      end
      S_DIV1W: begin
        if (sts_i.div_done) begin
          cmd_o.ld_idx = 1'b1;
          state_d = S_P;
        end
      end
      S_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gpvw_pkg::MUL_P;
        state_d = S_SDIV;
      end
      S_SDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = gpvw_pkg::DIV_SINE;
        state_d = S_SDIVW;
      end
      S_SDIVW: begin
        if (sts_i.div_done) begin
          cmd_o.ld_s = 1'b1;
          state_d = sts_i.k1 ? S_MAG : S_C1;
        end
      end
      S_C1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gpvw_pkg::MUL_SS;
        state_d = S_C2;
      end
      S_C2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gpvw_pkg::MUL_CUBE;
        state_d = S_C3;
      end
      S_C3: begin
        cmd_o.ld_sk_cube = 1'b1;
        state_d = S_MAG;
      end
      S_MAG: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = gpvw_pkg::MUL_MAG;
        cmd_o.sq_start = 1'b1;
        cmd_o.sq_sel   = gpvw_pkg::SQ_LEN;
        state_d = S_SQ2W;
      end
      S_SQ2W: begin
        if (sts_i.sq_done) begin
          cmd_o.ld_den = 1'b1;
          state_d = S_AX;
        end
      end
      S_AX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gpvw_pkg::MUL_AX;
        state_d = S_AXD;
      end
      S_AXD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = gpvw_pkg::DIV_AX;
        state_d = S_AXW;
      end
      S_AXW: begin
        if (sts_i.div_done) begin
          cmd_o.ld_sx = 1'b1;
          state_d = S_AY;
        end
      end
      S_AY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = gpvw_pkg::MUL_AY;
        state_d = S_AYD;
      end
      S_AYD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = gpvw_pkg::DIV_AY;
        state_d = S_AYW;
      end
      S_AYW: begin
        if (sts_i.div_done) begin
          cmd_o.ld_sy   = 1'b1;
          cmd_o.ptr_inc = 1'b1;
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

[hw/rtl/gravity_point_vertex_warp.sv]
// Top level of the gravity point vertex warp block.
// Depends on gpvw_pkg, gpvw_ctrl and gpvw_dpath.
`timescale 1ns / 1ps

// A clear or add transaction goes from idle to the done state, where its
// result loads into the output register once that register is free. The next
// transaction can be accepted in the cycle after the result loads. A map
// transaction walks the stored points one at a time. A point that misses the
// vertex, or sits on it, passes only the read, difference, square and hit
// check states. A hit skips the sine cubing states when the sine is not cubed.
// Most of a hit is the bit-serial square root (two passes per hit) and the
// bit-serial divider (four passes per hit: sine index, sine value, x shift and
// y shift). One transaction is in work at a time. The result register lets the
// next transaction be accepted while the previous result still waits.
module gravity_point_vertex_warp #(
  parameter int unsigned MAX_POINTS   = gpvw_pkg::MAX_POINTS_DEF,
  parameter int unsigned SINE_ENTRIES = gpvw_pkg::SINE_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gpvw_pkg::gpvw_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gpvw_pkg::gpvw_out_t  out_data_o
);

  gpvw_pkg::gpvw_cmd_t cmd;
  gpvw_pkg::gpvw_sts_t sts;

  gpvw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_mode_i   (in_data_i.mode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gpvw_dpath #(
    .MAX_POINTS   (MAX_POINTS),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
